[rtl/core/crx_pkg.sv]
package crx_pkg;

   // ASCII codes the classifier and the sequencer need
   localparam logic [7:0] CHAR_DASH = 8'h2D;
   localparam logic [7:0] CHAR_NUL  = 8'h00;

   // default depth of the command queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // character class of a range end
   typedef enum logic [1:0] {
      CLS_NONE,
      CLS_DIGIT,
      CLS_UPPER,
      CLS_LOWER
   } class_type;

   // work for one accepted item, in emission order:
   // literal dash or range run, own byte, trailing dash, terminator
   typedef struct packed {
      logic       dash;
      logic       run;
      logic       up;
      logic [7:0] from;
      logic [7:0] to;
      logic       chr;
      logic [7:0] ch;
      logic       tail;
      logic       eos;
   } cmd_type;

   function automatic class_type char_class(input logic [7:0] c);
      class_type k;
      k = CLS_NONE;
      if (c inside {[8'h30 : 8'h39]}) begin
         k = CLS_DIGIT;
      end else if (c inside {[8'h41 : 8'h5A]}) begin
         k = CLS_UPPER;
      end else if (c inside {[8'h61 : 8'h7A]}) begin
         k = CLS_LOWER;
      end
      return k;
   endfunction

endpackage

[rtl/core/crx_front.sv]
module crx_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        req_tdata,   // [7:0] in_char
   input  logic              req_tlast,   // last_char
   input  logic              queue_full,
   output logic              push,
   output crx_pkg::cmd_type  cmd
);

   logic [7:0] prev_ff, prev_in;
   logic       pend_ff, pend_in;

   assign req_tready = !queue_full;
   assign push       = req_tvalid && !queue_full;

   // classify the item against the held dash and its left neighbour
   always_comb begin
      crx_pkg::class_type k_prev;
      crx_pkg::class_type k_cur;
      logic               consumed;
      logic               pend_next;
      k_prev    = crx_pkg::char_class(prev_ff);
      k_cur     = crx_pkg::char_class(req_tdata);
      consumed  = 1'b0;
      pend_next = 1'b0;
      prev_in   = prev_ff;
      cmd       = '0;
      cmd.from  = prev_ff;
      cmd.to    = req_tdata;
      cmd.ch    = req_tdata;
      cmd.up    = prev_ff < req_tdata;

      if (pend_ff) begin
         if (k_prev != crx_pkg::CLS_NONE && k_prev == k_cur) begin
            cmd.run  = prev_ff != req_tdata;
            prev_in  = req_tdata;
            consumed = 1'b1;
         end else begin
            cmd.dash = 1'b1;
            prev_in  = crx_pkg::CHAR_DASH;
         end
      end

      if (!consumed) begin
         if (req_tdata == crx_pkg::CHAR_DASH) begin
            pend_next = 1'b1;
         end else begin
            cmd.chr = 1'b1;
            prev_in = req_tdata;
         end
      end

      pend_in = pend_next;
      // end of string: flush a held dash and return to reset state
      if (req_tlast) begin
         cmd.tail = pend_next;
         cmd.eos  = 1'b1;
         pend_in  = 1'b0;
         prev_in  = crx_pkg::CHAR_NUL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= crx_pkg::CHAR_NUL;
         pend_ff <= 1'b0;
      end else if (push) begin
         prev_ff <= prev_in;
         pend_ff <= pend_in;
      end
   end

endmodule

[rtl/core/crx_queue.sv]
module crx_queue #(
   parameter int DEPTH = crx_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  crx_pkg::cmd_type  push_cmd,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output crx_pkg::cmd_type  head_cmd
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   crx_pkg::cmd_type        slot_ff [DEPTH];
   logic [PTR_W-1:0]        wr_ff, wr_in;
   logic [PTR_W-1:0]        rd_ff, rd_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic                    do_push, do_pop;

   assign full       = cnt_ff == CNT_W'(DEPTH);
   assign head_valid = cnt_ff != '0;
   assign head_cmd   = slot_ff[rd_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // pointer wrap and occupancy
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // payload slots, no reset
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_cmd;
      end
   end

endmodule

[rtl/core/crx_back.sv]
module crx_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  crx_pkg::cmd_type  head_cmd,
   output logic              pop,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [7:0]        rsp_tdata,   // [7:0] out_char
   output logic              rsp_tuser,   // end_of_string
   output logic              rsp_tlast    // last_of_run
);

   // pending work of the current item
   logic       dash_ff, run_ff, up_ff, chr_ff, tail_ff, eos_ff;
   logic [7:0] cur_ff, to_ff, ch_ff;
   logic [7:0] next_val;
   logic       run_done;
   logic       busy, fire;

   assign next_val = up_ff ? cur_ff + 8'd1 : cur_ff - 8'd1;
   assign run_done = next_val == to_ff;
   assign busy     = dash_ff || run_ff || chr_ff || tail_ff || eos_ff;
   assign fire     = rsp_tvalid && rsp_tready;
   assign pop      = head_valid && (!busy || (fire && rsp_tlast));

   // pick the first pending result and flag whether it ends the item
   always_comb begin
      rsp_tvalid = busy;
      rsp_tdata  = crx_pkg::CHAR_NUL;
      rsp_tuser  = 1'b0;
      rsp_tlast  = 1'b0;
      if (dash_ff) begin
         rsp_tdata = crx_pkg::CHAR_DASH;
         rsp_tlast = !(run_ff || chr_ff || tail_ff || eos_ff);
      end else if (run_ff) begin
         rsp_tdata = next_val;
         rsp_tlast = run_done && !(chr_ff || tail_ff || eos_ff);
      end else if (chr_ff) begin
         rsp_tdata = ch_ff;
         rsp_tlast = !(tail_ff || eos_ff);
      end else if (tail_ff) begin
         rsp_tdata = crx_pkg::CHAR_DASH;
         rsp_tlast = !eos_ff;
      end else if (eos_ff) begin
         rsp_tuser = 1'b1;
         rsp_tlast = 1'b1;
      end
   end

   // control flags: load on pop, retire one result per handshake
   always_ff @(posedge clock) begin
      if (reset) begin
         dash_ff <= 1'b0;
         run_ff  <= 1'b0;
         chr_ff  <= 1'b0;
         tail_ff <= 1'b0;
         eos_ff  <= 1'b0;
      end else if (pop) begin
         dash_ff <= head_cmd.dash;
         run_ff  <= head_cmd.run;
         chr_ff  <= head_cmd.chr;
         tail_ff <= head_cmd.tail;
         eos_ff  <= head_cmd.eos;
      end else if (fire) begin
         if (dash_ff) begin
            dash_ff <= 1'b0;
         end else if (run_ff) begin
            run_ff <= !run_done;
         end else if (chr_ff) begin
            chr_ff <= 1'b0;
         end else if (tail_ff) begin
            tail_ff <= 1'b0;
         end else begin
            eos_ff <= 1'b0;
         end
      end
   end

   // payload: run counter and item bytes
   always_ff @(posedge clock) begin
      if (pop) begin
         cur_ff <= head_cmd.from;
         to_ff  <= head_cmd.to;
         up_ff  <= head_cmd.up;
         ch_ff  <= head_cmd.ch;
      end else if (fire && !dash_ff && run_ff) begin
         cur_ff <= next_val;
      end
   end

endmodule

[rtl/core/char_range_expander.sv]
// Character range expander.
// req_ channel takes one source byte per item in req_tdata, with req_tlast
// marking the final byte of a string. rsp_ channel returns the expanded
// string one byte per item in rsp_tdata; rsp_tuser marks the terminator
// item that closes each string, rsp_tlast the final result of one source
// byte. A source byte may cause no result (equal range ends, or a dash that
// is held for the next byte) or up to 26. The first result of a byte is
// presented once the byte has passed the command queue, written at the edge
// that accepts it, and the sequencer, loaded when it pops the queue head.
// The sequencer emits one result per cycle while rsp_tready is high; it pops
// the next command when it is idle or takes the last result of its item.
// The front classifies and queues up to QUEUE_DEPTH bytes ahead of the
// sequencer; req_tready drops while the queue is full.
// Reset clears the held dash, the left neighbour, the queue and the
// sequencer. A stall on rsp_tready holds the current result unchanged and
// backs up through the queue to req_tready.
module char_range_expander #(
   parameter int QUEUE_DEPTH = crx_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] in_char
   input  logic        req_tlast,    // last_char
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,    // [7:0] out_char
   output logic        rsp_tuser,    // end_of_string
   output logic        rsp_tlast     // last_of_run
);

   logic              push, full, pop, head_valid;
   crx_pkg::cmd_type  push_cmd, head_cmd;

   crx_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .queue_full (full),
      .push       (push),
      .cmd        (push_cmd)
   );

   crx_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   crx_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
